>>> rtl/assert_macros.svh
// assertion macros used by the port checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/owb_pkg.sv
// shared types and constants of the one-wire bus master
// no dependencies
package owb_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [CntW-1:0] RstLowDefault = 16'd24000;
  localparam logic [CntW-1:0] RstWaitDefault = 16'd24000;
  localparam logic [CntW-1:0] ReleaseDefault = 16'd50;
  localparam logic [CntW-1:0] SampleDefault = 16'd700;
  localparam logic [CntW-1:0] SlotEndDefault = 16'd2950;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RST_LOW  = 3'd0,
    REG_RST_WAIT = 3'd1,
    REG_RELEASE  = 3'd2,
    REG_SAMPLE   = 3'd3,
    REG_SLOT_END = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_SLOT0    = 3'd3,
    PH_SLOT1    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CntW-1:0] rst_low;
    logic [CntW-1:0] rst_wait;
    logic [CntW-1:0] release_at;
    logic [CntW-1:0] sample_at;
    logic [CntW-1:0] slot_end;
  } cfg_t;

endpackage

>>> rtl/one_wire_bus_master.sv
// one-wire bus master: reset pulse and byte exchange timing sequencer
// depends on owb_pkg and owb_cfg
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: start_req, tx_byte, line_in; tuser: cmd
//  m_axis    | out       | tdata: drive_low, busy_res, rx_byte; tlast: done_res
//  cfg       | in        | cfg_index (register), cfg_data (16-bit value)
//
// one transaction per clock tick of the bus timing; every input transaction
// yields one output transaction in the next cycle, through the output register
// a new input is taken every cycle while the output register is empty or drained
// rst clears the sequencer state and the output valid flag and sets default timings
// a stalled output holds its data and stalls the input side
module one_wire_bus_master import owb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // start_req, tx_byte[7:0], line_in, zero pad
  input  logic                s_axis_tuser,   // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // drive_low, busy_res, rx_byte[7:0], zero pad
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CntW-1:0]     cfg_data
);

  cfg_t             cfg;
  phase_t           phase, phase_next, cur_phase;
  logic [CntW-1:0]  cycle_count, count_next, cur_count;
  logic [2:0]       bit_index, bit_next, cur_bit;
  logic [ByteW-1:0] shift_reg, shift_next, cur_shift, shift_upd;
  logic [CntW:0]    count_inc;
  logic             slot_one, slot_last, sample_now;
  logic             start_req, cmd, line_in;
  logic [ByteW-1:0] tx_byte;
  logic             drive_low, busy_res, done_res;
  logic [ByteW-1:0] rx_byte;
  logic             in_fire;

  assign cfg_ready = 1'b1;

  owb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign start_req = s_axis_tdata[0];
  assign tx_byte   = s_axis_tdata[ByteW:1];
  assign line_in   = s_axis_tdata[ByteW+1];
  assign cmd       = s_axis_tuser;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // operation launch and slot timing
  always_comb begin
    cur_phase = phase;
    cur_count = cycle_count;
    cur_bit = bit_index;
    cur_shift = shift_reg;
    if (phase == PH_IDLE && start_req) begin
      cur_count = '0;
      if (!cmd) begin
        cur_phase = PH_RST_LOW;
      end else begin
        cur_bit = '0;
        cur_shift = tx_byte;
        cur_phase = tx_byte[0] ? PH_SLOT1 : PH_SLOT0;
      end
    end
    count_inc = {1'b0, cur_count} + {{CntW{1'b0}}, 1'b1};
    slot_one = (cur_phase == PH_SLOT1);
    slot_last = (count_inc >= {1'b0, cfg.slot_end});
    sample_now = (cur_count == cfg.sample_at) || (slot_last && (cur_count < cfg.sample_at));
    shift_upd = sample_now ? {slot_one & line_in, cur_shift[ByteW-1:1]} : cur_shift;
  end

  // next state
  always_comb begin
    phase_next = cur_phase;
    count_next = count_inc[CntW-1:0];
    bit_next = cur_bit;
    shift_next = cur_shift;
    unique case (cur_phase)
      PH_RST_LOW: begin
        if (count_inc >= {1'b0, cfg.rst_low}) begin
          phase_next = PH_RST_WAIT;
          count_next = '0;
        end
      end
      PH_RST_WAIT: begin
        if (count_inc >= {1'b0, cfg.rst_wait}) begin
          phase_next = PH_IDLE;
          count_next = '0;
        end
      end
      PH_SLOT0, PH_SLOT1: begin
        shift_next = shift_upd;
        if (slot_last) begin
          count_next = '0;
          if (cur_bit == 3'd7) begin
            phase_next = PH_IDLE;
            bit_next = '0;
          end else begin
            bit_next = cur_bit + 3'd1;
            phase_next = shift_upd[0] ? PH_SLOT1 : PH_SLOT0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        count_next = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    drive_low = 1'b0;
    busy_res = 1'b0;
    done_res = 1'b0;
    rx_byte = '0;
    unique case (cur_phase)
      PH_RST_LOW: begin
        busy_res = 1'b1;
        drive_low = 1'b1;
      end
      PH_RST_WAIT: begin
        busy_res = 1'b1;
        done_res = (count_inc >= {1'b0, cfg.rst_wait});
      end
      PH_SLOT0, PH_SLOT1: begin
        busy_res = 1'b1;
        drive_low = (cur_count < cfg.slot_end) && !(slot_one && (cur_count >= cfg.release_at));
        if (slot_last && cur_bit == 3'd7) begin
          done_res = 1'b1;
          rx_byte = shift_upd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cycle_count <= '0;
      bit_index <= '0;
      shift_reg <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      cycle_count <= count_next;
      bit_index <= bit_next;
      shift_reg <= shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {{(OutDataW-ByteW-2){1'b0}}, rx_byte, busy_res, drive_low};
      m_axis_tlast <= done_res;
    end
  end

endmodule

>>> rtl/owb_cfg.sv
// timing register file of the one-wire bus master
// depends on owb_pkg
module owb_cfg import owb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [CntW-1:0]    wr_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rst_low <= RstLowDefault;
      cfg.rst_wait <= RstWaitDefault;
      cfg.release_at <= ReleaseDefault;
      cfg.sample_at <= SampleDefault;
      cfg.slot_end <= SlotEndDefault;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RST_LOW:  cfg.rst_low <= wr_data;
        REG_RST_WAIT: cfg.rst_wait <= wr_data;
        REG_RELEASE:  cfg.release_at <= wr_data;
        REG_SAMPLE:   cfg.sample_at <= wr_data;
        REG_SLOT_END: cfg.slot_end <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/owb_checker.sv
// port-level checks of the one-wire bus master, bound to the top level
// depends on owb_pkg and assert_macros.svh
`include "assert_macros.svh"

module owb_checker import owb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  `ASSERT_SAME(a_done_busy, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1])
  `ASSERT_SAME(a_drive_busy, clk, rst, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])
  `ASSERT_SAME(a_rx_zero, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[9:2] == 8'd0)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `ASSERT_SAME(a_in_ready, clk, rst, !m_axis_tvalid, s_axis_tready)

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/testbench.sv
// self-checking bench for one_wire_bus_master: drives bus-tick transactions,
// predicts every output tick from its own timing model and compares them field by field
// depends on owb_pkg and the one_wire_bus_master rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import owb_pkg::*;

  localparam logic CMD_BUS_RESET = 1'b0;
  localparam logic CMD_EXCHANGE = 1'b1;

  typedef enum {LINE_NOISE, LINE_HIGH, LINE_LOW} line_mode_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx;
  } line_tick_t;

  class onewire_timing_model;
    cfg_t       timing;
    phase_t     phase;
    logic [CntW-1:0]  count;
    logic [2:0]       bit_idx;
    logic [ByteW-1:0] shreg;
    line_tick_t pending_ticks[$];
    int         mismatches;

    function new();
      timing.rst_low = RstLowDefault;
      timing.rst_wait = RstWaitDefault;
      timing.release_at = ReleaseDefault;
      timing.sample_at = SampleDefault;
      timing.slot_end = SlotEndDefault;
      phase = PH_IDLE;
      count = '0;
      bit_idx = '0;
      shreg = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] value);
      case (idx)
        REG_RST_LOW:  timing.rst_low = value;
        REG_RST_WAIT: timing.rst_wait = value;
        REG_RELEASE:  timing.release_at = value;
        REG_SAMPLE:   timing.sample_at = value;
        REG_SLOT_END: timing.slot_end = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_ticks.size();
    endfunction

    function void apply_tick(logic start, logic cmd, logic [ByteW-1:0] tx, logic line);
      line_tick_t r;
      logic [CntW:0] nxt;
      logic sends_one;
      logic slot_last;
      r = '0;
      if (phase == PH_IDLE && start) begin
        count = '0;
        if (cmd == CMD_BUS_RESET) begin
          phase = PH_RST_LOW;
        end else begin
          bit_idx = '0;
          shreg = tx;
          phase = tx[0] ? PH_SLOT1 : PH_SLOT0;
        end
      end
      nxt = {1'b0, count} + 1'b1;
      case (phase)
        PH_RST_LOW: begin
          r.drive_low = 1'b1;
          r.busy = 1'b1;
          if (nxt >= {1'b0, timing.rst_low}) begin
            phase = PH_RST_WAIT;
            count = '0;
          end else begin
            count = nxt[CntW-1:0];
          end
        end
        PH_RST_WAIT: begin
          r.busy = 1'b1;
          if (nxt >= {1'b0, timing.rst_wait}) begin
            phase = PH_IDLE;
            count = '0;
            r.done = 1'b1;
          end else begin
            count = nxt[CntW-1:0];
          end
        end
        PH_SLOT0, PH_SLOT1: begin
          sends_one = (phase == PH_SLOT1);
          slot_last = (nxt >= {1'b0, timing.slot_end});
          r.busy = 1'b1;
          r.drive_low = (count < timing.slot_end) && !(sends_one && count >= timing.release_at);
          // a sample point beyond the slot end falls back to the slot's last cycle
          if (count == timing.sample_at || (slot_last && count < timing.sample_at))
            shreg = {sends_one & line, shreg[ByteW-1:1]};
          if (slot_last) begin
            count = '0;
            if (bit_idx == 3'd7) begin
              phase = PH_IDLE;
              bit_idx = '0;
              r.done = 1'b1;
              r.rx = shreg;
            end else begin
              bit_idx = bit_idx + 1'b1;
              phase = shreg[0] ? PH_SLOT1 : PH_SLOT0;
            end
          end else begin
            count = nxt[CntW-1:0];
          end
        end
        default: begin
          phase = PH_IDLE;
          count = '0;
        end
      endcase
      pending_ticks.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_tick(logic drive, logic busy, logic done, logic [ByteW-1:0] rx);
      line_tick_t want;
      if (pending_ticks.size() == 0) begin
        report_mismatch("output transaction with no input pending");
        return;
      end
      want = pending_ticks.pop_front();
      if (drive !== want.drive_low)
        report_mismatch($sformatf("drive_low %b, predicted %b", drive, want.drive_low));
      if (busy !== want.busy)
        report_mismatch($sformatf("busy_res %b, predicted %b", busy, want.busy));
      if (done !== want.done)
        report_mismatch($sformatf("done_res %b, predicted %b", done, want.done));
      if (rx !== want.rx)
        report_mismatch($sformatf("rx_byte %h, predicted %h", rx, want.rx));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CntW-1:0]     cfg_data;

  onewire_timing_model model;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_request;
  int stall_left;
  int items_sent;

  one_wire_bus_master DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.check_tick(m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast,
                       m_axis_tdata[ByteW+1:2]);
  end

  function automatic logic line_level(line_mode_t mode);
    if (mode == LINE_HIGH)
      return 1'b1;
    if (mode == LINE_LOW)
      return 1'b0;
    return 1'($urandom_range(1));
  endfunction

  function automatic cfg_t random_timings();
    cfg_t t;
    t.rst_low = CntW'($urandom_range(12));
    t.rst_wait = CntW'($urandom_range(12));
    t.slot_end = CntW'($urandom_range(12));
    case ($urandom_range(3))
      0: t.release_at = '0;
      1: t.release_at = '1;
      default: t.release_at = CntW'($urandom_range(t.slot_end + 2));
    endcase
    case ($urandom_range(3))
      0: t.sample_at = '0;
      1: t.sample_at = '1;
      default: t.sample_at = CntW'($urandom_range(t.slot_end + 3));
    endcase
    return t;
  endfunction

  task automatic send_tick(logic start, logic cmd, logic [ByteW-1:0] tx, logic line);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InDataW'({line, tx, start});
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    model.apply_tick(start, cmd, tx, line);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (model.pending() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic program_timings(cfg_t t);
    drain_results();
    cfg_write(REG_RST_LOW, t.rst_low);
    cfg_write(REG_RST_WAIT, t.rst_wait);
    cfg_write(REG_RELEASE, t.release_at);
    cfg_write(REG_SAMPLE, t.sample_at);
    cfg_write(REG_SLOT_END, t.slot_end);
    // unmapped index, must leave the timings alone
    cfg_write(CfgIdxW'(REG_SLOT_END) + CfgIdxW'($urandom_range(1, 3)), CntW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_op(logic cmd, logic [ByteW-1:0] tx, line_mode_t mode);
    send_tick(1'b1, cmd, tx, line_level(mode));
    // start requests while busy must be ignored
    while (model.phase != PH_IDLE)
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), ByteW'($urandom),
                line_level(mode));
  endtask

  task automatic run_phase(int target, bit with_hold);
    int first;
    first = items_sent;
    while (items_sent - first < target) begin
      program_timings(random_timings());
      if (with_hold) begin
        stall_request = 300;
        with_hold = 1'b0;
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3))
            send_tick(1'b0, 1'($urandom_range(1)), ByteW'($urandom), 1'($urandom_range(1)));
        run_op(($urandom_range(3) == 0) ? CMD_BUS_RESET : CMD_EXCHANGE, ByteW'($urandom),
               line_mode_t'($urandom_range(2)));
      end
    end
  endtask

  initial begin
    model = new();
    items_sent = 0;
    stall_request = 0;
    tx_idle_pct = 18;
    rx_idle_pct = 70;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle tick at reset timings, then zero lengths everywhere
    send_tick(1'b0, CMD_EXCHANGE, 8'hFF, 1'b1);
    program_timings('0);
    run_op(CMD_BUS_RESET, 8'h00, LINE_NOISE);
    run_op(CMD_EXCHANGE, 8'hFF, LINE_HIGH);
    run_op(CMD_EXCHANGE, 8'h00, LINE_HIGH);
    run_op(CMD_EXCHANGE, 8'hFF, LINE_LOW);

    run_phase(230, 1'b1);
    tx_idle_pct = 70;
    rx_idle_pct = 18;
    run_phase(230, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(230, 1'b0);

    drain_results();
    repeat (8) @(negedge clk);
    if (model.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

>>> one_wire_bus_master.f
+incdir+rtl
rtl/owb_pkg.sv
rtl/owb_cfg.sv
rtl/one_wire_bus_master.sv
rtl/owb_checker.sv
bench/testbench.sv
